@@ hdl/tks_pkg.sv @@
`timescale 1ns / 1ps

package tks_pkg;

    // request codes carried on s_tuser
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam int STR_W      = 16;
    localparam int PAY_IN_W   = 32;
    localparam int RANK_IN_W  = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // status from the rank controller to the output stage
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic                 evict;
        logic [STR_W-1:0]     str;
        logic [CNT_OUT_W-1:0] count;
    } resp_t;

endpackage

@@ hdl/tks_payload_ram.sv @@
`timescale 1ns / 1ps

module tks_payload_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tks_rank_ctl.sv @@
`timescale 1ns / 1ps

module tks_rank_ctl import tks_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int RW      = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    output logic                 idle,
    input  logic [1:0]           req_type,
    input  logic [STR_W-1:0]     new_strength,
    input  logic [RANK_IN_W-1:0] read_rank,
    output resp_t                resp,
    input  logic                 resp_taken,
    output logic                 pay_wr_en,
    output logic [RW-1:0]        pay_wr_addr,
    output logic                 pay_rd_en,
    output logic [RW-1:0]        pay_rd_addr
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL     = CW'(ENTRIES);
    localparam logic [CW-1:0] FULL_M1  = CW'(ENTRIES - 1);
    localparam logic [RW-1:0] LAST_IDX = RW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_DEL      = 3'd2;
    localparam logic [2:0] ST_INS      = 3'd3;
    localparam logic [2:0] ST_INS_LAST = 3'd4;
    localparam logic [2:0] ST_RD       = 3'd5;
    localparam logic [2:0] ST_RESP     = 3'd6;

    typedef struct packed {
        logic [STR_W-1:0] str;
        logic [RW-1:0]    slot;
    } rank_ent_t;

    // rank-ordered table: strength copy and slot index per rank
    rank_ent_t rank_mem [ENTRIES];
    rank_ent_t mem_q_reg;

    logic       mem_re;
    logic [RW-1:0] mem_raddr;
    logic       mem_we;
    logic [RW-1:0] mem_waddr;
    rank_ent_t  mem_wdata;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [STR_W-1:0] op_str_reg, op_str_next;
    logic [RW-1:0]    new_slot_reg, new_slot_next;
    logic [STR_W-1:0] min_str_reg, min_str_next;
    logic [RW-1:0]    eslot_reg, eslot_next;
    logic [RW-1:0]    erank_reg, erank_next;
    logic             evict_reg, evict_next;
    logic             hit_reg, hit_next;
    logic [STR_W-1:0] out_str_reg, out_str_next;
    logic             rv_reg;
    logic [RW-1:0]    rtag_reg;

    logic          scan_take;
    logic [RW-1:0] scan_erank;
    logic [RW-1:0] scan_eslot;
    logic [CW-1:0] k_dec;
    logic [RW-1:0] rtag_inc;
    logic [RW-1:0] rtag_dec;
    rank_ent_t     new_ent;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rank_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= rank_mem[mem_raddr];
        end
    end

    // weakest entry so far, lowest slot on equal strength
    assign scan_take = (rtag_reg == '0)
                    || ($signed(mem_q_reg.str) < $signed(min_str_reg))
                    || ((mem_q_reg.str == min_str_reg) && (mem_q_reg.slot < eslot_reg));
    assign scan_erank = scan_take ? rtag_reg : erank_reg;
    assign scan_eslot = scan_take ? mem_q_reg.slot : eslot_reg;

    assign k_dec    = k_reg - CW'(1);
    assign rtag_inc = rtag_reg + RW'(1);
    assign rtag_dec = rtag_reg - RW'(1);

    always_comb begin
        new_ent.str  = op_str_reg;
        new_ent.slot = new_slot_reg;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        op_str_next   = op_str_reg;
        new_slot_next = new_slot_reg;
        min_str_next  = min_str_reg;
        eslot_next    = eslot_reg;
        erank_next    = erank_reg;
        evict_next    = evict_reg;
        hit_next      = hit_reg;
        out_str_next  = out_str_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = mem_q_reg;
        pay_wr_en     = 1'b0;
        pay_rd_en     = 1'b0;
        pay_rd_addr   = mem_q_reg.slot;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_str_next  = new_strength;
                    evict_next   = 1'b0;
                    hit_next     = 1'b0;
                    out_str_next = '0;
                    state_next   = ST_RESP;
                    unique case (req_type)
                        REQ_INSERT: begin
                            if (new_strength != '0) begin
                                if (cnt_reg == FULL) begin
                                    k_next     = '0;
                                    state_next = ST_SCAN;
                                end else begin
                                    new_slot_next = cnt_reg[RW-1:0];
                                    k_next        = cnt_reg;
                                    state_next    = ST_INS;
                                end
                            end
                        end
                        REQ_READ: begin
                            if (CNT_OUT_W'(read_rank) < CNT_OUT_W'(cnt_reg)) begin
                                mem_re     = 1'b1;
                                mem_raddr  = read_rank[RW-1:0];
                                state_next = ST_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (k_reg != FULL) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_reg[RW-1:0];
                    k_next    = k_reg + CW'(1);
                end
                if (rv_reg) begin
                    if (scan_take) begin
                        min_str_next = mem_q_reg.str;
                    end
                    eslot_next = scan_eslot;
                    erank_next = scan_erank;
                    if (rtag_reg == LAST_IDX) begin
                        new_slot_next = scan_eslot;
                        evict_next    = 1'b1;
                        k_next        = CW'(scan_erank) + CW'(1);
                        state_next    = ST_DEL;
                    end
                end
            end

            ST_DEL: begin
                // close the gap left by the evicted rank
                if (k_reg != FULL) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_reg[RW-1:0];
                    k_next    = k_reg + CW'(1);
                end
                if (rv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rtag_dec;
                    mem_wdata = mem_q_reg;
                end
                if ((k_reg == FULL) && !rv_reg) begin
                    cnt_next   = FULL_M1;
                    k_next     = FULL_M1;
                    state_next = ST_INS;
                end
            end

            ST_INS: begin
                // walk up from the tail, push weaker-or-equal entries down
                if (k_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_dec[RW-1:0];
                    k_next    = k_dec;
                end
                if (rv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rtag_inc;
                    if ($signed(mem_q_reg.str) > $signed(op_str_reg)) begin
                        mem_wdata  = new_ent;
                        pay_wr_en  = 1'b1;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_RESP;
                    end else if (rtag_reg == '0) begin
                        state_next = ST_INS_LAST;
                    end
                end else if (k_reg == '0) begin
                    state_next = ST_INS_LAST;
                end
            end

            ST_INS_LAST: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = new_ent;
                pay_wr_en  = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_RESP;
            end

            ST_RD: begin
                pay_rd_en    = 1'b1;
                pay_rd_addr  = mem_q_reg.slot;
                hit_next     = 1'b1;
                out_str_next = mem_q_reg.str;
                state_next   = ST_RESP;
            end

            ST_RESP: begin
                if (resp_taken) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= mem_re;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        op_str_reg   <= op_str_next;
        new_slot_reg <= new_slot_next;
        min_str_reg  <= min_str_next;
        eslot_reg    <= eslot_next;
        erank_reg    <= erank_next;
        evict_reg    <= evict_next;
        hit_reg      <= hit_next;
        out_str_reg  <= out_str_next;
        rtag_reg     <= mem_raddr;
    end

    assign idle        = (state_reg == ST_IDLE);
    assign pay_wr_addr = new_slot_reg;

    always_comb begin
        resp.valid = (state_reg == ST_RESP);
        resp.hit   = hit_reg;
        resp.evict = evict_reg;
        resp.str   = out_str_reg;
        resp.count = CNT_OUT_W'(cnt_reg);
    end

endmodule

@@ hdl/top_k_strength_sorted_table_core.sv @@
`timescale 1ns / 1ps

// Sorted top-k table of scan results, strongest first.
// Input channel s_*: one request per transfer. s_tuser holds the request
// kind (insert, read at rank, clear); s_tdata holds strength, payload, rank.
// Output channel m_*: exactly one result per request, in request order.
// m_tuser flags a read that found an entry; m_tdata holds strength, payload,
// the entry count after the request and the eviction flag.
// One request is worked at a time; s_tready is high only while idle.
// A read looks up the rank table, then the payload memory; clear and
// ignored requests go straight to the result. The rank table lives in a
// one-port-read, one-port-write memory read one rank per cycle, and an
// insert walks it once (plus a weakest-entry scan and a gap-closing pass
// when full).
// A result sits in an output register; if m_tready is low the controller
// holds its next result until the register drains, and accepts no new
// request until its result has moved to that register.
// Reset empties the table at once; no clearing pass is needed.
module top_k_strength_sorted_table_core import tks_pkg::*; #(
    parameter int ENTRIES      = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] new_strength, [47:16] new_payload, [53:48] read_rank, [55:54] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] out_strength, [47:16] out_payload, [54:48] entry_count, [55] evicted
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] entry_valid
    output logic [0:0]             m_tuser
);

    localparam int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int STORE_W = (PAYLOAD_BITS < PAY_IN_W) ? PAYLOAD_BITS : PAY_IN_W;

    logic                 accept;
    logic                 ctl_idle;
    resp_t                resp;
    logic                 resp_load;
    logic                 pay_wr_en;
    logic [RW-1:0]        pay_wr_addr;
    logic                 pay_rd_en;
    logic [RW-1:0]        pay_rd_addr;
    logic [STORE_W-1:0]   pay_rd_data;
    logic [STORE_W-1:0]   pay_reg;
    logic [PAY_IN_W-1:0]  out_pay;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    assign s_tready = ctl_idle;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            pay_reg <= s_tdata[16 +: STORE_W];
        end
    end

    tks_rank_ctl #(
        .ENTRIES (ENTRIES),
        .RW      (RW)
    ) u_rank_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (accept),
        .idle         (ctl_idle),
        .req_type     (s_tuser),
        .new_strength (s_tdata[15:0]),
        .read_rank    (s_tdata[53:48]),
        .resp         (resp),
        .resp_taken   (resp_load),
        .pay_wr_en    (pay_wr_en),
        .pay_wr_addr  (pay_wr_addr),
        .pay_rd_en    (pay_rd_en),
        .pay_rd_addr  (pay_rd_addr)
    );

    tks_payload_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (STORE_W),
        .AW    (RW)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (pay_wr_en),
        .wr_addr (pay_wr_addr),
        .wr_data (pay_reg),
        .rd_en   (pay_rd_en),
        .rd_addr (pay_rd_addr),
        .rd_data (pay_rd_data)
    );

    // load the output register when it is empty or draining
    assign resp_load = resp.valid && (!m_tvalid_reg || m_tready);
    assign out_pay   = resp.hit ? PAY_IN_W'(pay_rd_data) : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (resp_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_tdata_reg <= {resp.evict, resp.count, out_pay, resp.str};
            m_tuser_reg <= resp.hit;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

@@ hdl/tks_checker.sv @@
`timescale 1ns / 1ps

module tks_checker #(
    parameter int ENTRIES = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[54:48] <= 7'(ENTRIES)))
        else $error("entry count beyond table size");

    a_hit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[15:0] != 16'd0) && !m_tdata[55])
        else $error("found entry with zero strength or eviction flag");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[47:0] == 48'd0))
        else $error("miss carries nonzero entry data");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[55] |-> (m_tdata[54:48] == 7'(ENTRIES)))
        else $error("eviction reported while table not full");

endmodule

bind top_k_strength_sorted_table_core tks_checker #(.ENTRIES(ENTRIES)) u_tks_checker (.*);

@@ dv/top_k_strength_sorted_table_core_tb.sv @@
`timescale 1ns / 1ps

module top_k_strength_sorted_table_core_tb;
    import tks_pkg::*;

    localparam int          SLOTS         = 16;
    localparam int          RANDOM_REQS   = 550;
    localparam int          SETTLE_CYCLES = 3 * SLOTS + 20;
    localparam int          STUCK_LIMIT   = 4000;
    localparam logic [1:0]  REQ_SPARE     = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] strength;
        logic [31:0]        payload;
        logic [5:0]         rank;
        bit                 drain;
    } scan_req_t;

    typedef struct {
        bit                 hit;
        logic signed [15:0] strength;
        logic [31:0]        payload;
        logic [6:0]         count;
        bit                 evicted;
    } table_result_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    top_k_strength_sorted_table_core #(
        .ENTRIES      (SLOTS),
        .PAYLOAD_BITS (32)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow of the table
    logic signed [15:0] slot_str [SLOTS];
    logic [31:0]        slot_pay [SLOTS];
    int unsigned        rank_order [$];

    scan_req_t     scan_reqs [$];
    table_result_t results_due [$];
    scan_req_t     req_in_flight;
    table_result_t next_due;

    int n_accepted  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_evictions = 0;
    int n_hits      = 0;
    int n_clears    = 0;
    int n_ignored   = 0;
    int stuck_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // idle mix: sender light / receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        if (n_accepted < 190) return 23;
        if (n_accepted < 380) return 47;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_accepted < 190) return 47;
        if (n_accepted < 380) return 23;
        return 0;
    endfunction

    function automatic void apply_request(input scan_req_t rq, output table_result_t res);
        int  victim;
        int  pos;
        bit  free_found;
        res.hit      = 1'b0;
        res.strength = '0;
        res.payload  = '0;
        res.evicted  = 1'b0;
        case (rq.kind)
            REQ_INSERT: begin
                if (rq.strength == 0) begin
                    n_ignored++;
                end else begin
                    victim     = 0;
                    free_found = 1'b0;
                    // first free slot, else weakest with lowest index on ties
                    for (int i = 0; i < SLOTS && !free_found; i++) begin
                        if (slot_str[i] == 0) begin
                            victim     = i;
                            free_found = 1'b1;
                        end else if (slot_str[i] < slot_str[victim]) begin
                            victim = i;
                        end
                    end
                    if (!free_found) begin
                        pos = 0;
                        foreach (rank_order[r])
                            if (rank_order[r] == victim) pos = r;
                        rank_order.delete(pos);
                        res.evicted = 1'b1;
                        n_evictions++;
                    end
                    slot_str[victim] = rq.strength;
                    slot_pay[victim] = rq.payload;
                    // new entry goes ahead of equal strengths
                    pos = 0;
                    while (pos < rank_order.size() && slot_str[rank_order[pos]] > rq.strength)
                        pos++;
                    rank_order.insert(pos, victim);
                end
            end
            REQ_READ: begin
                if (rq.rank < rank_order.size()) begin
                    res.hit      = 1'b1;
                    res.strength = slot_str[rank_order[rq.rank]];
                    res.payload  = slot_pay[rank_order[rq.rank]];
                    n_hits++;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) slot_str[i] = '0;
                rank_order.delete();
                n_clears++;
            end
            default: ;
        endcase
        res.count = 7'(rank_order.size());
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic signed [15:0] strength,
                           input logic [31:0] payload, input logic [5:0] rank,
                           input bit drain);
        scan_req_t rq;
        rq.kind     = kind;
        rq.strength = strength;
        rq.payload  = payload;
        rq.rank     = rank;
        rq.drain    = drain;
        scan_reqs.push_back(rq);
    endtask

    function automatic logic signed [15:0] pick_strength();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return 16'(int'($urandom_range(6)) - 3);  // ties and zeros
        if (sel < 50) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        return 16'($urandom);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(req_in_flight, next_due);
                results_due.push_back(next_due);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (scan_reqs.size() != 0 && !(scan_reqs[0].drain && results_due.size() != 0)
                        && $urandom_range(99) >= sender_idle_pct()) begin
                    req_in_flight = scan_reqs.pop_front();
                    s_tdata  <= {2'b00, req_in_flight.rank, req_in_flight.payload,
                                 req_in_flight.strength};
                    s_tuser  <= req_in_flight.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                    n_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser[0] !== want.hit) begin
                        $display("%0t: entry_valid expected %0b actual %0b",
                                 $time, want.hit, m_tuser[0]);
                        n_errors++;
                    end
                    if (m_tdata[15:0] !== want.strength) begin
                        $display("%0t: strength expected %0d actual %0d",
                                 $time, want.strength, $signed(m_tdata[15:0]));
                        n_errors++;
                    end
                    if (m_tdata[47:16] !== want.payload) begin
                        $display("%0t: payload expected %h actual %h",
                                 $time, want.payload, m_tdata[47:16]);
                        n_errors++;
                    end
                    if (m_tdata[54:48] !== want.count) begin
                        $display("%0t: entry count expected %0d actual %0d",
                                 $time, want.count, m_tdata[54:48]);
                        n_errors++;
                    end
                    if (m_tdata[55] !== want.evicted) begin
                        $display("%0t: evicted expected %0b actual %0b",
                                 $time, want.evicted, m_tdata[55]);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // watchdog: no progress on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int sel;
        for (int i = 0; i < SLOTS; i++) begin
            slot_str[i] = '0;
            slot_pay[i] = '0;
        end

        // directed: empty reads, strength and payload extremes, zero insert, ties
        add_req(REQ_READ,   16'sd0,     32'h0000_0000, 6'd0,  1'b0);
        add_req(REQ_READ,   16'($urandom), $urandom,   6'd63, 1'b0);
        add_req(REQ_INSERT, 16'sh7fff,  32'hffff_ffff, 6'd63, 1'b0);
        add_req(REQ_INSERT, 16'sh8000,  32'h0000_0000, 6'd0,  1'b0);
        add_req(REQ_INSERT, 16'sd0,     32'ha5a5_5a5a, 6'd0,  1'b0);
        add_req(REQ_INSERT, 16'sd1,     32'h0000_0001, 6'd0,  1'b0);
        add_req(REQ_INSERT, -16'sd1,    32'h8000_0000, 6'd0,  1'b0);
        add_req(REQ_INSERT, 16'sd1,     32'h0000_0002, 6'd0,  1'b0);
        add_req(REQ_SPARE,  16'sd5,     32'h1234_5678, 6'd1,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd0,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd1,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd2,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd4,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd5,  1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd63, 1'b0);
        add_req(REQ_CLEAR,  16'sh7fff,  32'hffff_ffff, 6'd63, 1'b0);
        add_req(REQ_READ,   16'sd0,     32'h0,         6'd0,  1'b0);

        // random: mostly inserts and reads so the table fills and evicts; rare clears
        for (int n = 0; n < RANDOM_REQS; n++) begin
            sel = $urandom_range(999);
            if (sel < 15)
                add_req(REQ_CLEAR, 16'($urandom), $urandom, 6'($urandom), n == 300);
            else if (sel < 35)
                add_req(REQ_SPARE, 16'($urandom), $urandom, 6'($urandom), n == 300);
            else if (sel < 600)
                add_req(REQ_INSERT, pick_strength(), $urandom, 6'($urandom), n == 300);
            else
                add_req(REQ_READ, 16'($urandom), $urandom,
                        $urandom_range(4) == 0 ? 6'($urandom) : 6'($urandom_range(SLOTS + 1)),
                        n == 300);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (scan_reqs.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d requests, %0d results: %0d evictions, %0d read hits,",
                 n_accepted, n_results, n_evictions, n_hits);
        $display("%0d clears, %0d zero-strength inserts dropped", n_clears, n_ignored);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
